FILE: hw/rtl/lzss_pkg.sv
// Package with shared constants and types of the LZSS ring encoder.
`timescale 1ns / 1ps
`default_nettype none
package lzss_pkg;
	localparam int RING_DEPTH   = 4096;
	localparam int RING_AW      = $clog2(RING_DEPTH);
	localparam int MAX_MATCH    = 18;
	localparam int MIN_MATCH    = 3;
	localparam int CNT_W        = $clog2(MAX_MATCH + 1);
	localparam int SCAN_READS   = RING_DEPTH + MAX_MATCH - 1;
	localparam int SCAN_W       = $clog2(SCAN_READS + 1);
	localparam int GROUP_TOKENS = 8;
	localparam int GROUP_BYTES  = 2 * GROUP_TOKENS;
	localparam int GB_W         = $clog2(GROUP_BYTES + 1);
	localparam int GT_W         = $clog2(GROUP_TOKENS + 1);
	localparam logic [RING_AW-1:0] RING_START_RST = 12'hFEE;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_COMMIT,
		ST_POST,
		ST_SEND,
		ST_END
	} lzss_state_t;
endpackage
`default_nettype wire

FILE: hw/rtl/lzss_ring_encoder_top.sv
// Top level of the LZSS ring encoder: scan engine, token coder and group output.
// A byte that completes the lookahead starts a scan of all 4096 offsets (one ring read
// per cycle), then the ring writes of the bytes that each token uses.
// Bytes that code no token are taken one per cycle; in_stall holds input off outside idle.
// A stream end flushes one token after another and then clears the ring.
// After reset the ring is cleared in one pass during which no request is taken.
`timescale 1ns / 1ps
`default_nettype none
module lzss_ring_encoder_top
	import lzss_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         in_byte,
	input  wire logic               in_last,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic      [7:0]         out_byte,
	output logic                    out_run_last,
	output logic                    out_stream_end,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [RING_AW-1:0] cfg_data
);
	lzss_state_t state_q, state_d;

	logic [RING_AW-1:0] ring_start_q;
	logic [RING_AW-1:0] wp_q;
	logic               active_q;
	logic               last_q;
	logic               final_q;
	logic [RING_AW:0]   clr_q;

	logic [7:0]       la_q [MAX_MATCH];
	logic [CNT_W-1:0] la_cnt_q;

	logic [7:0]       gstore_q [GROUP_BYTES];
	logic [7:0]       gctl_q;
	logic [GT_W-1:0]  gtok_q;
	logic [GB_W-1:0]  gb_q;
	logic [GB_W-1:0]  send_idx_q;

	logic [SCAN_W-1:0]  rd_cnt_q;
	logic               vld_s1;
	logic [SCAN_W-1:0]  idx_s1;
	logic [7:0]         win_s2 [MAX_MATCH];
	logic               win_vld_s2;
	logic [RING_AW-1:0] off_s2;
	logic [CNT_W-1:0]   best_len_q;
	logic [RING_AW-1:0] best_off_q;
	logic [CNT_W-1:0]   used_q;

	logic               ram_we, ram_re;
	logic [RING_AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]         ram_wdata, ram_rdata;

	logic       in_acc, out_free, out_load, send_last, scan_done;
	logic [7:0] send_byte;

	logic [MAX_MATCH-1:0] eq_self [MAX_MATCH];
	logic [MAX_MATCH-1:0] lane_ok;
	logic [RING_AW-1:0]   rel;
	logic                 ov;
	logic [CNT_W-1:0]     jd;
	logic [CNT_W-1:0]     lead, cand_len;

	lzss_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;

	// Self-compare of the lookahead for matches that overlap the bytes being written.
	always_comb begin
		for (int j = 0; j < MAX_MATCH; j++) begin
			for (int k = 0; k < MAX_MATCH; k++) begin
				eq_self[j][k] = (k >= j) ? (la_q[k] == la_q[(k - j) % MAX_MATCH]) : 1'b0;
			end
		end
	end

	always_comb begin
		rel = off_s2 - wp_q;
		ov  = rel >= RING_AW'(RING_DEPTH - MAX_MATCH + 1);
		jd  = CNT_W'((RING_AW + 1)'(RING_DEPTH) - {1'b0, rel});
		for (int k = 0; k < MAX_MATCH; k++) begin
			if (ov && (CNT_W'(k) >= jd)) begin
				lane_ok[k] = eq_self[jd][k];
			end else begin
				lane_ok[k] = (win_s2[k] == la_q[k]);
			end
		end
		lead = CNT_W'(MAX_MATCH);
		for (int k = MAX_MATCH - 1; k >= 0; k--) begin
			if (!lane_ok[k]) begin
				lead = CNT_W'(k);
			end
		end
		cand_len = (lead > la_cnt_q) ? la_cnt_q : lead;
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = wp_q;
		ram_wdata = la_q[0];
		ram_re    = 1'b0;
		ram_raddr = rd_cnt_q[RING_AW-1:0];
		out_load  = 1'b0;
		scan_done = win_vld_s2 && (off_s2 == RING_AW'(RING_DEPTH - 1));
		send_last = (send_idx_q == gb_q);
		send_byte = (send_idx_q == '0) ? gctl_q
			: gstore_q[4'(send_idx_q - GB_W'(1))];
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q[RING_AW-1:0];
				ram_wdata = 8'h00;
				if (clr_q == (RING_AW + 1)'(RING_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_acc && (in_last || la_cnt_q == CNT_W'(MAX_MATCH - 1))) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				ram_re = rd_cnt_q < SCAN_W'(SCAN_READS);
				if (scan_done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				ram_we = 1'b1;
				if (used_q == CNT_W'(1)) begin
					state_d = ST_POST;
				end
			end
			ST_POST: begin
				if (gtok_q == GT_W'(GROUP_TOKENS)) begin
					state_d = ST_SEND;
				end else if (last_q) begin
					if (la_cnt_q != '0) begin
						state_d = ST_SCAN;
					end else if (gtok_q != '0) begin
						state_d = ST_SEND;
					end else begin
						state_d = ST_END;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SEND: begin
				if (out_free) begin
					out_load = 1'b1;
					if (send_last) begin
						if (final_q) begin
							state_d = ST_END;
						end else if (last_q) begin
							state_d = ST_SCAN;
						end else begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			ST_END: begin
				state_d = ST_CLEAR;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_start_q <= RING_START_RST;
			wp_q         <= RING_START_RST;
			active_q     <= 1'b0;
			last_q       <= 1'b0;
			final_q      <= 1'b0;
			clr_q        <= '0;
			la_cnt_q     <= '0;
			gctl_q       <= '0;
			gtok_q       <= '0;
			gb_q         <= '0;
			send_idx_q   <= '0;
			rd_cnt_q     <= '0;
			vld_s1       <= 1'b0;
			win_vld_s2   <= 1'b0;
			best_len_q   <= '0;
			used_q       <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				ring_start_q <= cfg_data;
				if (!active_q) begin
					wp_q <= cfg_data;
				end
			end
			if (out_valid && !out_stall && !out_load) begin
				out_valid <= 1'b0;
			end
			if (state_q != ST_SCAN && state_d == ST_SCAN) begin
				rd_cnt_q   <= '0;
				vld_s1     <= 1'b0;
				win_vld_s2 <= 1'b0;
				best_len_q <= '0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= (state_d == ST_IDLE) ? '0 : clr_q + 1'b1;
				end
				ST_IDLE: begin
					if (in_acc) begin
						la_cnt_q <= la_cnt_q + 1'b1;
						last_q   <= in_last;
						active_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (ram_re) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					vld_s1     <= ram_re;
					win_vld_s2 <= vld_s1 && (idx_s1 >= SCAN_W'(MAX_MATCH - 1));
					if (win_vld_s2 && cand_len >= best_len_q) begin
						best_len_q <= cand_len;
					end
				end
				ST_DECIDE: begin
					if (best_len_q >= CNT_W'(MIN_MATCH)) begin
						gb_q   <= gb_q + GB_W'(2);
						used_q <= best_len_q;
					end else begin
						gctl_q[gtok_q[2:0]] <= 1'b1;
						gb_q   <= gb_q + GB_W'(1);
						used_q <= CNT_W'(1);
					end
					gtok_q <= gtok_q + 1'b1;
				end
				ST_COMMIT: begin
					wp_q     <= wp_q + 1'b1;
					la_cnt_q <= la_cnt_q - 1'b1;
					used_q   <= used_q - 1'b1;
				end
				ST_POST: begin
					final_q    <= last_q && (la_cnt_q == '0);
					send_idx_q <= '0;
				end
				ST_SEND: begin
					if (out_load) begin
						out_valid  <= 1'b1;
						send_idx_q <= send_idx_q + 1'b1;
						if (send_last) begin
							gctl_q <= '0;
							gtok_q <= '0;
							gb_q   <= '0;
						end
					end
				end
				ST_END: begin
					wp_q     <= (cfg_valid && cfg_ready) ? cfg_data : ring_start_q;
					active_q <= 1'b0;
					clr_q    <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			la_q[la_cnt_q] <= in_byte;
		end
		if (state_q == ST_COMMIT) begin
			for (int k = 0; k < MAX_MATCH - 1; k++) begin
				la_q[k] <= la_q[k + 1];
			end
		end
		if (state_q == ST_SCAN) begin
			idx_s1 <= rd_cnt_q;
			if (vld_s1) begin
				for (int k = 0; k < MAX_MATCH - 1; k++) begin
					win_s2[k] <= win_s2[k + 1];
				end
				win_s2[MAX_MATCH-1] <= ram_rdata;
				off_s2 <= RING_AW'(idx_s1 - SCAN_W'(MAX_MATCH - 1));
			end
			if (win_vld_s2 && cand_len >= best_len_q) begin
				best_off_q <= off_s2;
			end
		end
		if (state_q == ST_DECIDE) begin
			if (best_len_q >= CNT_W'(MIN_MATCH)) begin
				gstore_q[gb_q[3:0]] <= best_off_q[7:0];
				gstore_q[4'(gb_q + GB_W'(1))] <=
					{best_off_q[11:8], 4'(best_len_q - CNT_W'(MIN_MATCH))};
			end else begin
				gstore_q[gb_q[3:0]] <= la_q[0];
			end
		end
		if (out_load) begin
			out_byte       <= send_byte;
			out_run_last   <= send_last && (!last_q || final_q);
			out_stream_end <= send_last && final_q;
		end
	end

	a_la_bound: assert property (@(posedge clk) disable iff (!arst_n)
		la_cnt_q <= CNT_W'(MAX_MATCH))
		else $error("Lookahead count exceeds its capacity.");

	a_group_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(gb_q <= GB_W'(GROUP_BYTES)) && (gtok_q <= GT_W'(GROUP_TOKENS)))
		else $error("Group store overflow.");

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("Ring read and write in the same cycle.");

	a_end_marks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stream_end |-> out_run_last)
		else $error("Stream end without request end mark.");

	a_commit_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DECIDE |=> (used_q != '0) && (used_q <= la_cnt_q))
		else $error("Token length exceeds the lookahead.");
endmodule
`default_nettype wire

FILE: hw/rtl/lzss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lzss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

FILE: sim/tb_lzss_ring_encoder_top.sv
// Testbench for the LZSS ring encoder: directed and random streams checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_lzss_ring_encoder_top;
	import lzss_pkg::*;

	localparam int IDLE_LIMIT = 200000;
	localparam int SETTLE     = 4400;

	typedef struct {
		logic [7:0] code;
		logic       run_last;
		logic       stream_end;
	} coded_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [7:0] in_byte;
	logic in_last;
	logic out_valid;
	logic out_stall;
	logic [7:0] out_byte;
	logic out_run_last;
	logic out_stream_end;
	logic cfg_valid;
	logic cfg_ready;
	logic [RING_AW-1:0] cfg_data;

	lzss_ring_encoder_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .in_last(in_last),
		.out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
		.out_run_last(out_run_last), .out_stream_end(out_stream_end),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Predictor state.
	logic [7:0] hist_ring[RING_DEPTH];
	logic [RING_AW-1:0] wr_pos;
	logic [RING_AW-1:0] start_pos;
	logic [7:0] look_buf[MAX_MATCH];
	int look_cnt;
	logic [7:0] grp_buf[GROUP_BYTES];
	logic [7:0] grp_ctl;
	int grp_tokens;
	int grp_bytes;
	bit enc_idle;

	coded_t pending_codes[$];
	coded_t step_codes[$];
	int errors;
	int idle_cycles;
	int items_sent;
	bit quiet;
	int stall_burst;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic emit_code(input logic [7:0] b);
		coded_t c;
		c.code = b;
		c.run_last = 0;
		c.stream_end = 0;
		step_codes = {step_codes, c};
	endtask

	task automatic flush_group();
		emit_code(grp_ctl);
		for (int i = 0; i < grp_bytes && i < GROUP_BYTES; i++)
			emit_code(grp_buf[i]);
		grp_ctl = 0;
		grp_tokens = 0;
		grp_bytes = 0;
	endtask

	function automatic int match_len(input int off, input int lim);
		int k;
		int pos;
		int d;
		logic [7:0] v;
		for (k = 0; k < lim; k++) begin
			pos = (off + k) & (RING_DEPTH - 1);
			d = (pos - int'(wr_pos)) & (RING_DEPTH - 1);
			v = (d < k) ? look_buf[d] : hist_ring[pos];
			if (v != look_buf[k])
				break;
		end
		return k;
	endfunction

	task automatic code_token();
		int lim;
		int best_len;
		int best_off;
		int len;
		int used;
		lim = (look_cnt < MAX_MATCH) ? look_cnt : MAX_MATCH;
		best_len = 0;
		best_off = 0;
		for (int off = 0; off < RING_DEPTH; off++) begin
			len = match_len(off, lim);
			if (len >= best_len) begin
				best_len = len;
				best_off = off;
			end
		end
		if (best_len >= MIN_MATCH) begin
			grp_buf[grp_bytes % GROUP_BYTES] = best_off[7:0];
			grp_bytes++;
			grp_buf[grp_bytes % GROUP_BYTES] = {best_off[11:8], 4'(best_len - MIN_MATCH)};
			grp_bytes++;
			used = best_len;
		end else begin
			grp_ctl[grp_tokens % GROUP_TOKENS] = 1'b1;
			grp_buf[grp_bytes % GROUP_BYTES] = look_buf[0];
			grp_bytes++;
			used = 1;
		end
		for (int i = 0; i < used; i++) begin
			hist_ring[wr_pos] = look_buf[i];
			wr_pos = wr_pos + 1'b1;
		end
		for (int i = 0; i < MAX_MATCH - used; i++)
			look_buf[i] = look_buf[i + used];
		look_cnt -= used;
		grp_tokens++;
		if (grp_tokens == GROUP_TOKENS)
			flush_group();
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic l);
		step_codes.delete();
		enc_idle = 0;
		if (look_cnt >= MAX_MATCH)
			code_token();
		look_buf[look_cnt] = b;
		look_cnt++;
		if (!l) begin
			if (look_cnt == MAX_MATCH)
				code_token();
		end else begin
			while (look_cnt > 0)
				code_token();
			if (grp_tokens > 0)
				flush_group();
			if (step_codes.size() > 0)
				step_codes[step_codes.size() - 1].stream_end = 1;
			foreach (hist_ring[i])
				hist_ring[i] = 8'h00;
			wr_pos = start_pos;
			enc_idle = 1;
		end
		if (step_codes.size() > 0)
			step_codes[step_codes.size() - 1].run_last = 1;
		pending_codes = {pending_codes, step_codes};
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic l);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_byte(b, l);
		items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_codes.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_ring_start(input logic [RING_AW-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		start_pos = v;
		if (enc_idle)
			wr_pos = v;
	endtask

	task automatic send_stream(input logic [7:0] data[$]);
		foreach (data[i])
			send_byte(data[i], i == data.size() - 1);
		wait_drained();
	endtask

	task automatic test_literals_and_extremes();
		send_stream('{8'hFF});
		send_stream('{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01});
	endtask

	task automatic test_overlapping_runs();
		logic [7:0] data[$];
		// A run longer than the longest match, then a short tail cut at stream end.
		for (int i = 0; i < 24; i++)
			data = {data, 8'h3C};
		send_stream(data);
	endtask

	task automatic test_ring_start_extremes();
		write_ring_start(12'h000);
		send_stream('{8'h00, 8'h00, 8'h00, 8'h7E});
		write_ring_start(12'hFFF);
		send_stream('{8'h12, 8'h34, 8'h12, 8'h34, 8'h12, 8'h34, 8'h80});
		write_ring_start(RING_START_RST);
	endtask

	task automatic test_random_streams();
		logic [7:0] data[$];
		int len;
		int alpha;
		while (items_sent < 140) begin
			if ($urandom_range(0, 2) == 0) begin
				write_ring_start(RING_AW'($urandom_range(0, RING_DEPTH - 1)));
			end
			if (items_sent > 115)
				quiet = 1;
			len = $urandom_range(1, 30);
			alpha = $urandom_range(0, 3);
			data.delete();
			for (int i = 0; i < len; i++) begin
				if (alpha == 0)
					data = {data, 8'($urandom_range(0, 255))};
				else if ($urandom_range(0, 9) == 0 && i >= 3)
					data = {data, data[i - $urandom_range(1, 3)]};
				else
					data = {data, 8'($urandom_range(0, alpha) * 8'h41)};
			end
			send_stream(data);
		end
	endtask

	always @(posedge clk) begin
		if (quiet || !arst_n) begin
			out_stall <= 1'b0;
			stall_burst <= 0;
		end else if (stall_burst > 0) begin
			out_stall <= 1'b1;
			stall_burst <= stall_burst - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_burst <= $urandom_range(0, 7);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		coded_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_codes.size() == 0) begin
				report_mismatch("unexpected byte", out_byte, 0);
			end else begin
				want = pending_codes.pop_front();
				if (out_byte !== want.code)
					report_mismatch("out_byte", out_byte, want.code);
				if (out_run_last !== want.run_last)
					report_mismatch("out_run_last", out_run_last, want.run_last);
				if (out_stream_end !== want.stream_end)
					report_mismatch("out_stream_end", out_stream_end, want.stream_end);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("lzss_ring_encoder_top: mismatch");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		in_last = 1'b0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		errors = 0;
		idle_cycles = 0;
		items_sent = 0;
		quiet = 0;
		stall_burst = 0;
		foreach (hist_ring[i])
			hist_ring[i] = 8'h00;
		foreach (look_buf[i])
			look_buf[i] = 8'h00;
		start_pos = RING_START_RST;
		wr_pos = RING_START_RST;
		look_cnt = 0;
		grp_ctl = 0;
		grp_tokens = 0;
		grp_bytes = 0;
		enc_idle = 1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_literals_and_extremes();
		test_overlapping_runs();
		test_ring_start_extremes();
		test_random_streams();
		if (errors == 0 && pending_codes.size() == 0) begin
			$display("lzss_ring_encoder_top: match");
		end else begin
			$display("lzss_ring_encoder_top: mismatch");
		end
		$finish;
	end
endmodule
`default_nettype wire

FILE: sim.f
hw/rtl/lzss_pkg.sv
hw/rtl/lzss_ram.sv
hw/rtl/lzss_ring_encoder_top.sv
sim/tb_lzss_ring_encoder_top.sv
